// File: design/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg: shared types, constants and tables for the power of ten block
// Holds binary64 tables of powers of ten and their reciprocals, the link type
// between cells and the multiplier sequencer states.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int BINARY_STEPS_DEF = 5;
	localparam int TABLE_STEPS      = 5;    // steps with a finite factor
	localparam int HI_BITS          = 8;    // magnitude bits above the direct index

	localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;

	typedef struct packed {
		logic        go;
		logic [63:0] val;
	} link_t;

	typedef enum logic [1:0] {
		FM_IDLE,
		FM_MUL,
		FM_RND
	} fm_state_t;

	function automatic logic [63:0] limit_value(input logic neg);
		return neg ? POS_ZERO : POS_INF;
	endfunction

	function automatic logic [63:0] direct_power(input logic neg, input logic [3:0] idx);
		logic [63:0] r;
		r = 64'h3FF0_0000_0000_0000;
		if (!neg) begin
			case (idx)
				4'd0:  r = 64'h3FF0_0000_0000_0000;
				4'd1:  r = 64'h4024_0000_0000_0000;
				4'd2:  r = 64'h4059_0000_0000_0000;
				4'd3:  r = 64'h408F_4000_0000_0000;
				4'd4:  r = 64'h40C3_8800_0000_0000;
				4'd5:  r = 64'h40F8_6A00_0000_0000;
				4'd6:  r = 64'h412E_8480_0000_0000;
				4'd7:  r = 64'h4163_12D0_0000_0000;
				4'd8:  r = 64'h4197_D784_0000_0000;
				4'd9:  r = 64'h41CD_CD65_0000_0000;
				4'd10: r = 64'h4202_A05F_2000_0000;
				4'd11: r = 64'h4237_4876_E800_0000;
				4'd12: r = 64'h426D_1A94_A200_0000;
				4'd13: r = 64'h42A2_309C_E540_0000;
				4'd14: r = 64'h42D6_BCC4_1E90_0000;
				4'd15: r = 64'h430C_6BF5_2634_0000;
				default: r = 64'h3FF0_0000_0000_0000;
			endcase
		end else begin
			case (idx)
				4'd0:  r = 64'h3FF0_0000_0000_0000;
				4'd1:  r = 64'h3FB9_9999_9999_999A;
				4'd2:  r = 64'h3F84_7AE1_47AE_147B;
				4'd3:  r = 64'h3F50_624D_D2F1_A9FC;
				4'd4:  r = 64'h3F1A_36E2_EB1C_432D;
				4'd5:  r = 64'h3EE4_F8B5_88E3_68F1;
				4'd6:  r = 64'h3EB0_C6F7_A0B5_ED8D;
				4'd7:  r = 64'h3E7A_D7F2_9ABC_AF48;
				4'd8:  r = 64'h3E45_798E_E230_8C3A;
				4'd9:  r = 64'h3E11_2E0B_E826_D695;
				4'd10: r = 64'h3DDB_7CDF_D9D7_BDBB;
				4'd11: r = 64'h3DA5_FD7F_E179_6495;
				4'd12: r = 64'h3D71_9799_812D_EA11;
				4'd13: r = 64'h3D3C_25C2_6849_7682;
				4'd14: r = 64'h3D06_849B_86A1_2B9B;
				4'd15: r = 64'h3CD2_03AF_9EE7_5616;
				default: r = 64'h3FF0_0000_0000_0000;
			endcase
		end
		return r;
	endfunction

	// 10^(16*2^k) or its reciprocal, k below TABLE_STEPS
	function automatic logic [63:0] step_factor(input logic neg, input logic [2:0] k);
		logic [63:0] r;
		r = limit_value(neg);
		case (k)
			3'd0: r = neg ? 64'h3C9C_D2B2_97D8_89BC : 64'h4341_C379_37E0_8000;
			3'd1: r = neg ? 64'h3949_F623_D5A8_A733 : 64'h4693_B8B5_B505_6E17;
			3'd2: r = neg ? 64'h32A5_0FFD_44F4_A73D : 64'h4D38_4F03_E93F_F9F5;
			3'd3: r = neg ? 64'h255B_BA08_CF8C_979D : 64'h5A82_7748_F930_1D32;
			3'd4: r = neg ? 64'h0AC8_0628_64AC_6F43 : 64'h7515_4FDD_7F73_BF3C;
			default: r = limit_value(neg);
		endcase
		return r;
	endfunction

endpackage

// File: design/dpt_fmul.sv
// ----------------------------------------------------------------------------
// dpt_fmul: iterative binary64 multiplier
// Positive operands, b a normal constant. Four 27x27 partial products, one a
// cycle, then a round-to-nearest-even step with subnormal output.
// ----------------------------------------------------------------------------
module dpt_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] y
);
	import dpt_pkg::*;

	fm_state_t            st_q, st_d;
	logic [1:0]           cnt_q;
	logic [105:0]         acc_q;
	logic [52:0]          ma_q, mb_q;
	logic signed [12:0]   es_q;
	logic [63:0]          y_q;
	logic                 done_q;
	logic                 a_inf, a_zero;

	logic [26:0]          pa, pb;
	logic [53:0]          pp;
	logic [105:0]         pp_sh;

	logic [105:0]         nrm;
	logic signed [12:0]   e0, e2;
	logic [52:0]          sig;
	logic [53:0]          sum;
	logic                 inc;
	logic [12:0]          shamt;
	logic [6:0]           shc;
	logic [105:0]         shf;
	logic                 lost, sinc;
	logic [52:0]          sigs;
	logic [63:0]          rnd_y;

	// an infinite operand stays infinite; zero and subnormal a only meet
	// factors below one, where the product falls under half the least subnormal
	assign a_inf  = (a[62:52] == 11'h7FF);
	assign a_zero = (a[62:52] == 11'h000);

	always_comb begin
		st_d = st_q;
		case (st_q)
			FM_IDLE: if (start && !a_inf && !a_zero) st_d = FM_MUL;
			FM_MUL:  if (cnt_q == 2'd3) st_d = FM_RND;
			FM_RND:  st_d = FM_IDLE;
			default: st_d = FM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FM_IDLE;
		else         st_q <= st_d;
	end

	// partial product select: cnt bit 1 picks a half, bit 0 picks b half
	always_comb begin
		pa = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		pb = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pp = pa * pb;
		case (cnt_q)
			2'd0:    pp_sh = 106'(pp);
			2'd1:    pp_sh = 106'(pp) << 27;
			2'd2:    pp_sh = 106'(pp) << 27;
			2'd3:    pp_sh = 106'(pp) << 54;
			default: pp_sh = 106'(pp);
		endcase
	end

	// normalize, round to nearest even, subnormal path by right shift
	always_comb begin
		if (acc_q[105]) begin
			nrm = acc_q;
			e0  = es_q + 13'sd1;
		end else begin
			nrm = acc_q << 1;
			e0  = es_q;
		end
		sig = nrm[105:53];
		inc = nrm[52] & ((|nrm[51:0]) | sig[0]);
		sum = 54'(sig) + 54'(inc);
		e2  = sum[53] ? e0 + 13'sd1 : e0;

		shamt = 13'd1 - 13'(e0);
		shc   = (shamt > 13'd110) ? 7'd110 : shamt[6:0];
		shf   = nrm >> shc;
		lost  = |(nrm & ~({106{1'b1}} << shc));
		sigs  = shf[105:53];
		sinc  = shf[52] & ((|shf[51:0]) | lost | sigs[0]);

		if (e0 < 13'sd1)
			rnd_y = 64'(sigs) + 64'(sinc);
		else if (e2 > 13'sd2046)
			rnd_y = POS_INF;
		else
			rnd_y = {1'b0, e2[10:0], sum[53] ? 52'd0 : sum[51:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				FM_IDLE: begin
					cnt_q <= 2'd0;
					if (start && (a_inf || a_zero)) done_q <= 1'b1;
				end
				FM_MUL:  cnt_q <= cnt_q + 2'd1;
				FM_RND:  done_q <= 1'b1;
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			FM_IDLE: begin
				if (start) begin
					y_q   <= a_inf ? POS_INF : POS_ZERO;
					ma_q  <= {1'b1, a[51:0]};
					mb_q  <= {1'b1, b[51:0]};
					es_q  <= 13'(a[62:52]) + 13'(b[62:52]) - 13'sd1023;
					acc_q <= '0;
				end
			end
			FM_MUL:  acc_q <= acc_q + pp_sh;
			FM_RND:  y_q <= rnd_y;
			default: y_q <= y_q;
		endcase
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// File: design/dpt_cell.sv
// ----------------------------------------------------------------------------
// dpt_cell: one step of the binary exponent walk
// Multiplies the incoming value by 10^(16*2^K) or its reciprocal when its
// exponent bit is set (+inf/+0 past the table), else hands it on registered.
// ----------------------------------------------------------------------------
module dpt_cell #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dpt_pkg::link_t prev,
	input  logic          bit_set,
	input  logic          neg,
	output dpt_pkg::link_t next
);
	import dpt_pkg::*;

	logic        pass_q;
	logic [63:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pass_q <= 1'b0;
		else         pass_q <= prev.go && !(bit_set && (K < TABLE_STEPS));
	end

	// past binary64 range the factor is infinity or zero outright
	always_ff @(posedge clk) begin
		if (prev.go) val_q <= bit_set ? limit_value(neg) : prev.val;
	end

	generate
		if (K < TABLE_STEPS) begin : g_mul
			logic        fm_done;
			logic [63:0] fm_y;

			dpt_fmul u_fmul (
				.clk   (clk),
				.arst_n(arst_n),
				.start (prev.go && bit_set),
				.a     (prev.val),
				.b     (step_factor(neg, 3'(K))),
				.done  (fm_done),
				.y     (fm_y)
			);

			assign next.go  = pass_q | fm_done;
			assign next.val = fm_done ? fm_y : val_q;
		end else begin : g_lim
			assign next.go  = pass_q;
			assign next.val = val_q;
		end
	endgenerate

endmodule

// File: design/decimal_power_of_ten_double.sv
// ----------------------------------------------------------------------------
// decimal_power_of_ten_double: 10^e as a binary64 bit pattern
// Direct table for the low four exponent bits, then a chain of step cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel s_*: one beat carries a signed 12-bit decimal exponent.
//  - Master channel m_*: one beat per input beat, the binary64 pattern of 10^e.
//  - One exponent is in work at a time; s_tready drops after a beat is taken
//    and returns once its result has moved into the output register.
//  - Path from the accepting edge to m_tvalid: the lookup register loads
//    at that edge, then each step cell registers the value when its
//    exponent bit is clear, or runs it through its multiplier when set
//    (four 27x27 partial products, then rounding), then the value passes
//    the skid and output registers.
//  - s_tready comes back with m_tvalid, so a new exponent is taken only
//    once the last result has left the skid register.
//  - Magnitudes with a bit at step BINARY_STEPS or above saturate at the
//    lookup to +inf (e >= 0) or +0 (e < 0); every cell then just registers it.
//  - The output register holds its beat while m_tready is low; a new
//    exponent may be taken meanwhile, and its result waits in a skid
//    register until the output beat is taken.
//  - Reset clears all handshake state; no beat is pending afterwards.
// ----------------------------------------------------------------------------
module decimal_power_of_ten_double #(
	parameter int BINARY_STEPS = dpt_pkg::BINARY_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [11:0] exponent_in, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // [63:0] power_bits
);
	import dpt_pkg::*;

	logic               busy_q;
	logic               start_q;
	logic [63:0]        v0_q;
	logic [HI_BITS-1:0] bits_q;
	logic               neg_q;
	logic               hold_valid_q;
	logic [63:0]        hold_q;
	logic               m_valid_q;
	logic [63:0]        m_data_q;

	logic               s_acc;
	logic               move;
	logic               neg_in;
	logic [11:0]        mag;
	logic [HI_BITS-1:0] hi;
	logic               sat;

	link_t              lk [0:BINARY_STEPS];

	assign s_acc  = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign move   = hold_valid_q && (!m_valid_q || m_tready);

	// two's complement magnitude; -2048 wraps to 0x800 and saturates
	assign neg_in = s_tdata[11];
	assign mag    = neg_in ? (12'd0 - s_tdata[11:0]) : s_tdata[11:0];
	assign hi     = mag[11:4];
	assign sat    = (BINARY_STEPS < HI_BITS) ? ((hi >> BINARY_STEPS) != '0) : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			start_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			start_q <= s_acc;
			if (s_acc)      busy_q <= 1'b1;
			else if (move)  busy_q <= 1'b0;
			if (lk[BINARY_STEPS].go) hold_valid_q <= 1'b1;
			else if (move)           hold_valid_q <= 1'b0;
			if (move)          m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			v0_q   <= sat ? limit_value(neg_in) : direct_power(neg_in, mag[3:0]);
			bits_q <= sat ? '0 : hi;
			neg_q  <= neg_in;
		end
		if (lk[BINARY_STEPS].go) hold_q <= lk[BINARY_STEPS].val;
		if (move) m_data_q <= hold_q;
	end

	assign lk[0].go  = start_q;
	assign lk[0].val = v0_q;

	generate
		for (genvar k = 0; k < BINARY_STEPS; k++) begin : g_cell
			logic b;
			if (k < HI_BITS) begin : g_b
				assign b = bits_q[k];
			end else begin : g_z
				assign b = 1'b0;
			end
			dpt_cell #(.K(k)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.prev   (lk[k]),
				.bit_set(b),
				.neg    (neg_q),
				.next   (lk[k+1])
			);
		end
	endgenerate

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: design/dpt_checker.sv
// ----------------------------------------------------------------------------
// dpt_checker: port-level checks for decimal_power_of_ten_double
// Handshake stability, single-beat-in-work behavior and a clear sign bit.
// ----------------------------------------------------------------------------
module dpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while one is in work");

	a_new_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with no beat in work");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[63])
		else $error("power of ten with sign bit set");

endmodule

bind decimal_power_of_ten_double dpt_checker u_dpt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
